[rtl/core/slie_pkg.sv]
package slie_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 2;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

[rtl/core/sequential_list_insert_erase_unit.sv]
// Channel   Handshake            Payload
// command   start / busy         i_mode, i_position, i_value
// result    o_strobe (1 cycle)   o_status, o_count, o_read_value
//
// A command is taken on a clock edge with start high and busy low.
// Insert: S_SHIFT moves the entries from position on up by one, then S_PUT writes the value;
// erase: S_CAPT, then S_SHIFT moves later entries down; read: S_CAPT; rejected or no-op commands: busy stays low.
// The list memory has one read and one write port: one entry moves per cycle.
// Synchronous active-low reset empties the list; memory contents are not cleared.
// The result strobe lasts one cycle and cannot be held off.
module sequential_list_insert_erase_unit #(
    parameter int CAPACITY = slie_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [slie_pkg::MODE_W-1:0]         i_mode,
    input  logic [slie_pkg::POS_W-1:0]          i_position,
    input  logic signed [slie_pkg::DATA_W-1:0]  i_value,
    output logic                                o_strobe,
    output logic [slie_pkg::STATUS_W-1:0]       o_status,
    output logic [slie_pkg::COUNT_W-1:0]        o_count,
    output logic signed [slie_pkg::DATA_W-1:0]  o_read_value
);

    localparam int AW = $clog2(CAPACITY);

    slie_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic signed [slie_pkg::DATA_W-1:0] mem_wdata;
    logic signed [slie_pkg::DATA_W-1:0] mem_rdata;

    slie_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_read_value(o_read_value),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    slie_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

[rtl/core/slie_mem.sv]
module slie_mem #(
    parameter int CAPACITY = slie_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                                i_clk,
    input  slie_pkg::t_mem_ctl                  i_ctl,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [slie_pkg::DATA_W-1:0]  i_wdata,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [slie_pkg::DATA_W-1:0]  o_rdata
);

    logic signed [slie_pkg::DATA_W-1:0] r_mem [CAPACITY];
    logic signed [slie_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/slie_seq.sv]
module slie_seq #(
    parameter int CAPACITY = slie_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [slie_pkg::MODE_W-1:0]            i_mode,
    input  logic [slie_pkg::POS_W-1:0]             i_position,
    input  logic signed [slie_pkg::DATA_W-1:0]     i_value,
    output logic                                   o_strobe,
    output logic [slie_pkg::STATUS_W-1:0]          o_status,
    output logic [slie_pkg::COUNT_W-1:0]           o_count,
    output logic signed [slie_pkg::DATA_W-1:0]     o_read_value,
    output slie_pkg::t_mem_ctl                     o_mem_ctl,
    output logic [AW-1:0]                          o_waddr,
    output logic signed [slie_pkg::DATA_W-1:0]     o_wdata,
    output logic [AW-1:0]                          o_raddr,
    input  logic signed [slie_pkg::DATA_W-1:0]     i_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > slie_pkg::POS_W) ? CW : slie_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CAPT  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_PUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_wa, n_wa;
    logic [AW-1:0] r_pos, n_pos;
    logic signed [slie_pkg::DATA_W-1:0] r_val, n_val;
    logic signed [slie_pkg::DATA_W-1:0] r_res, n_res;
    logic [slie_pkg::STATUS_W-1:0] r_status, n_status;
    logic r_strobe, n_strobe;
    logic r_pend, n_pend;
    logic r_up, n_up;
    logic r_ins, n_ins;
    logic r_erase, n_erase;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cap_x;
    logic [AW-1:0] src_step;
    logic [AW-1:0] src_dst;

    assign pos_x = XW'(i_position);
    assign cnt_x = XW'(r_count);
    assign cap_x = XW'(CAPACITY);

    // shared index unit: next source and its destination, direction set per op
    assign src_step = r_up ? r_src + 1'b1 : r_src - 1'b1;
    assign src_dst  = r_up ? r_src - 1'b1 : r_src + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_src    = r_src;
        n_wa     = r_wa;
        n_pos    = r_pos;
        n_val    = r_val;
        n_res    = r_res;
        n_status = r_status;
        n_strobe = 1'b0;
        n_pend   = r_pend;
        n_up     = r_up;
        n_ins    = r_ins;
        n_erase  = r_erase;

        o_mem_ctl.we = 1'b0;
        o_mem_ctl.re = 1'b0;
        o_waddr      = r_wa;
        o_wdata      = i_rdata;
        o_raddr      = r_src;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_mode) inside
                        slie_pkg::MODE_INSERT: begin
                            if (cnt_x >= cap_x) begin
                                n_strobe = 1'b1;
                                n_status = slie_pkg::ST_FULL;
                                n_res    = '0;
                            end else if (pos_x > cnt_x) begin
                                n_strobe = 1'b1;
                                n_status = slie_pkg::ST_RANGE;
                                n_res    = '0;
                            end else begin
                                n_pos   = AW'(pos_x);
                                n_val   = i_value;
                                n_src   = AW'(cnt_x - 1'b1);
                                n_left  = CW'(cnt_x - pos_x);
                                n_up    = 1'b0;
                                n_pend  = 1'b0;
                                n_ins   = 1'b1;
                                n_erase = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        slie_pkg::MODE_ERASE, slie_pkg::MODE_READ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = slie_pkg::ST_EMPTY;
                                n_res    = '0;
                            end else if (pos_x >= cnt_x) begin
                                n_strobe = 1'b1;
                                n_status = slie_pkg::ST_RANGE;
                                n_res    = '0;
                            end else begin
                                o_mem_ctl.re = 1'b1;
                                o_raddr      = AW'(pos_x);
                                n_pos   = AW'(pos_x);
                                n_src   = AW'(pos_x + 1'b1);
                                n_left  = CW'(cnt_x - pos_x - 1'b1);
                                n_up    = 1'b1;
                                n_pend  = 1'b0;
                                n_ins   = 1'b0;
                                n_erase = (i_mode == slie_pkg::MODE_ERASE);
                                n_state = S_CAPT;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = slie_pkg::ST_OK;
                            n_res    = '0;
                        end
                    endcase
                end
            end
            S_CAPT: begin
                n_res = i_rdata;
                if (r_erase) begin
                    n_state = S_SHIFT;
                end else begin
                    n_strobe = 1'b1;
                    n_status = slie_pkg::ST_OK;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle while reading the next
                o_mem_ctl.we = r_pend;
                if (r_left != '0) begin
                    o_mem_ctl.re = 1'b1;
                    n_wa   = src_dst;
                    n_src  = src_step;
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (r_ins) begin
                        n_state = S_PUT;
                    end else begin
                        n_count  = r_count - 1'b1;
                        n_strobe = 1'b1;
                        n_status = slie_pkg::ST_OK;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_PUT: begin
                o_mem_ctl.we = 1'b1;
                o_waddr      = r_pos;
                o_wdata      = r_val;
                n_count  = r_count + 1'b1;
                n_strobe = 1'b1;
                n_status = slie_pkg::ST_OK;
                n_res    = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_src    <= n_src;
        r_wa     <= n_wa;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_res    <= n_res;
        r_status <= n_status;
        r_up     <= n_up;
        r_ins    <= n_ins;
        r_erase  <= n_erase;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_count      = cnt_x[slie_pkg::COUNT_W-1:0];
    assign o_read_value = r_res;

endmodule

[dv/sequential_list_insert_erase_checker.sv]
`timescale 1ns / 100ps

module sequential_list_insert_erase_checker #(
    parameter int CAPACITY = slie_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [slie_pkg::MODE_W-1:0]         i_mode,
    input  logic [slie_pkg::POS_W-1:0]          i_position,
    input  logic signed [slie_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_strobe,
    input  logic [slie_pkg::STATUS_W-1:0]       i_status,
    input  logic [slie_pkg::COUNT_W-1:0]        i_count,
    input  logic signed [slie_pkg::DATA_W-1:0]  i_read_value,
    input  logic                                i_end_of_test,
    output int                                  o_err_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic [slie_pkg::STATUS_W-1:0] status;
        logic [slie_pkg::COUNT_W-1:0]  count;
        logic [slie_pkg::DATA_W-1:0]   read_value;
    } t_list_result;

    logic signed [slie_pkg::DATA_W-1:0] list_q [CAPACITY];
    int unsigned                        occupancy = 0;
    t_list_result                       list_results_q [$];
    t_list_result                       oldest;
    int                                 err_count = 0;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns list check: %s", $time, msg);
        err_count++;
    endtask

    // applies one command to the shadow list and returns the result beat it should give
    function automatic t_list_result apply_list_command(
        input logic [slie_pkg::MODE_W-1:0]        mode,
        input logic [slie_pkg::POS_W-1:0]         pos,
        input logic signed [slie_pkg::DATA_W-1:0] val
    );
        t_list_result r;
        int unsigned  p;
        int unsigned  i;
        r            = '0;
        r.status     = slie_pkg::ST_OK;
        p            = pos;
        case (mode)
            slie_pkg::MODE_INSERT: begin
                // fullness wins over a bad position
                if (occupancy >= CAPACITY) begin
                    r.status = slie_pkg::ST_FULL;
                end else if (p > occupancy) begin
                    r.status = slie_pkg::ST_RANGE;
                end else begin
                    for (i = occupancy; i > p; i--)
                        list_q[i] = list_q[i-1];
                    list_q[p] = val;
                    occupancy++;
                end
            end
            slie_pkg::MODE_ERASE, slie_pkg::MODE_READ: begin
                if (occupancy == 0) begin
                    r.status = slie_pkg::ST_EMPTY;
                end else if (p >= occupancy) begin
                    r.status = slie_pkg::ST_RANGE;
                end else begin
                    r.read_value = list_q[p];
                    if (mode == slie_pkg::MODE_ERASE) begin
                        for (i = p; i + 1 < occupancy; i++)
                            list_q[i] = list_q[i+1];
                        occupancy--;
                    end
                end
            end
            default: ;
        endcase
        r.count = occupancy[slie_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occupancy = 0;
            list_results_q.delete();
        end else begin
            if (i_strobe) begin
                if (list_results_q.size() == 0) begin
                    flag_mismatch("result beat with no command outstanding");
                end else begin
                    oldest = list_results_q.pop_front();
                    if (i_status !== oldest.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                i_status, oldest.status));
                    if (i_count !== oldest.count)
                        flag_mismatch($sformatf("count %0d, expected %0d",
                                                i_count, oldest.count));
                    if (i_read_value !== oldest.read_value)
                        flag_mismatch($sformatf("read_value %h, expected %h",
                                                i_read_value, oldest.read_value));
                end
            end
            if (i_start && !i_busy)
                list_results_q.push_back(apply_list_command(i_mode, i_position, i_value));
        end
        o_pending   <= list_results_q.size();
        o_err_count <= err_count;
    end

    always @(posedge i_end_of_test) begin
        foreach (list_results_q[k])
            flag_mismatch($sformatf("result never seen: status %0d count %0d value %h",
                                    list_results_q[k].status, list_results_q[k].count,
                                    list_results_q[k].read_value));
    end

endmodule

[dv/sequential_list_insert_erase_unit_tb.sv]
`timescale 1ns / 100ps

module sequential_list_insert_erase_unit_tb;

    localparam int CAPACITY   = slie_pkg::CAPACITY_DEF;
    localparam int NUM_RANDOM = 1525;
    // unused mode encoding, must behave as a no-op
    localparam logic [slie_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                start        = 1'b0;
    logic [slie_pkg::MODE_W-1:0]         i_mode       = slie_pkg::MODE_READ;
    logic [slie_pkg::POS_W-1:0]          i_position   = '0;
    logic signed [slie_pkg::DATA_W-1:0]  i_value      = '0;
    logic                                busy;
    logic                                o_strobe;
    logic [slie_pkg::STATUS_W-1:0]       o_status;
    logic [slie_pkg::COUNT_W-1:0]        o_count;
    logic signed [slie_pkg::DATA_W-1:0]  o_read_value;
    logic                                end_of_test  = 1'b0;
    int                                  fail_count;
    int                                  pending;

    // rough list length, only used to steer positions toward legal ones
    int unsigned                list_len = 0;
    bit                         no_idle  = 1'b0;

    always #10 i_clk = ~i_clk;

    sequential_list_insert_erase_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_read_value (o_read_value)
    );

    sequential_list_insert_erase_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_count       (o_count),
        .i_read_value  (o_read_value),
        .i_end_of_test (end_of_test),
        .o_err_count   (fail_count),
        .o_pending     (pending)
    );

    // drive one command beat, wait for it to be taken, then maybe idle a few cycles
    task automatic issue_command(
        input logic [slie_pkg::MODE_W-1:0]        mode,
        input logic [slie_pkg::POS_W-1:0]         pos,
        input logic signed [slie_pkg::DATA_W-1:0] val
    );
        logic [31:0] junk;
        start      <= 1'b1;
        i_mode     <= mode;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (mode == slie_pkg::MODE_INSERT && list_len < CAPACITY && pos <= list_len)
            list_len++;
        else if (mode == slie_pkg::MODE_ERASE && list_len != 0 && pos < list_len)
            list_len--;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 19) begin
                junk       = $urandom;
                start      <= 1'b0;
                i_mode     <= junk[slie_pkg::MODE_W-1:0];
                i_position <= junk[slie_pkg::MODE_W +: slie_pkg::POS_W];
                i_value    <= $urandom;
                @(posedge i_clk);
            end
        end
    endtask

    function automatic logic signed [slie_pkg::DATA_W-1:0] pick_value();
        logic signed [slie_pkg::DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7FFF_FFFF;
                2: v = '0;
                default: v = -1;
            endcase
        end
        return v;
    endfunction

    // mostly legal positions with the ends favored, some junk across the full 5 bits
    function automatic logic [slie_pkg::POS_W-1:0] pick_position(
        input logic [slie_pkg::MODE_W-1:0] mode
    );
        int unsigned top;
        int unsigned sel;
        int unsigned p;
        top = (mode == slie_pkg::MODE_INSERT) ? list_len :
              ((list_len == 0) ? 0 : list_len - 1);
        sel = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 31);
        else if (sel == 0)
            p = 0;
        else if (sel == 1)
            p = top;
        else
            p = $urandom_range(0, top);
        return p[slie_pkg::POS_W-1:0];
    endfunction

    function automatic logic [slie_pkg::MODE_W-1:0] pick_mode(input int unsigned phase);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_UNUSED;
        case (phase)
            0: return (r < 75) ? slie_pkg::MODE_INSERT :
                      (r < 88) ? slie_pkg::MODE_ERASE : slie_pkg::MODE_READ;
            1: return (r < 18) ? slie_pkg::MODE_INSERT :
                      (r < 80) ? slie_pkg::MODE_ERASE : slie_pkg::MODE_READ;
            default: return (r < 38) ? slie_pkg::MODE_INSERT :
                            (r < 70) ? slie_pkg::MODE_ERASE : slie_pkg::MODE_READ;
        endcase
    endfunction

    initial begin
        int unsigned                  phase;
        int                           wait_cycles;
        logic [slie_pkg::MODE_W-1:0]  mode;

        phase       = 2;
        wait_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, ends, middle, range and no-op cases
        issue_command(slie_pkg::MODE_READ,   5'd0,  32'sd7);
        issue_command(slie_pkg::MODE_ERASE,  5'd0,  32'sd7);
        issue_command(slie_pkg::MODE_INSERT, 5'd1,  32'sd11);
        issue_command(MODE_UNUSED,           5'd31, -32'sd1);
        issue_command(slie_pkg::MODE_INSERT, 5'd0,  32'sh8000_0000);
        issue_command(slie_pkg::MODE_INSERT, 5'd1,  32'sh7FFF_FFFF);
        issue_command(slie_pkg::MODE_INSERT, 5'd0,  32'sd0);
        issue_command(slie_pkg::MODE_INSERT, 5'd3,  -32'sd1);
        issue_command(slie_pkg::MODE_INSERT, 5'd2,  32'sh5A5A_A5A5);
        issue_command(slie_pkg::MODE_READ,   5'd4,  32'sd0);
        issue_command(slie_pkg::MODE_READ,   5'd5,  32'sd0);
        issue_command(slie_pkg::MODE_READ,   5'd31, 32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd31, 32'sd0);
        issue_command(slie_pkg::MODE_INSERT, 5'd6,  32'sd3);
        issue_command(slie_pkg::MODE_INSERT, 5'd31, 32'sd3);
        issue_command(slie_pkg::MODE_ERASE,  5'd0,  32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd3,  32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd1,  32'sd0);
        issue_command(slie_pkg::MODE_READ,   5'd0,  32'sd0);
        issue_command(MODE_UNUSED,           5'd0,  32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd0,  32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd0,  32'sd0);
        issue_command(slie_pkg::MODE_ERASE,  5'd0,  32'sd0);

        // random: randomly chosen fill, drain and mixed stretches so the list hits full and empty
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 40 == 0)
                phase = $urandom_range(0, 2);
            no_idle = (n >= 500 && n < 800);
            mode = pick_mode(phase);
            issue_command(mode, pick_position(mode), pick_value());
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0 && wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
